// ----- rtl/wsp_pkg.sv -----
package wsp_pkg;

  // Fixed-point format of coordinates and coefficients.
  localparam int FRAC_BITS = 16;
  localparam int COORD_W   = 32;

  // One product after the floor shift, and the dot-product sum.
  localparam int PROD_W = 2 * COORD_W - FRAC_BITS;
  localparam int SUM_W  = PROD_W + 2;

  // Divider widths: magnitude of clip x/y, divisor clip w, quotient bits.
  localparam int MAG_W     = SUM_W;
  localparam int DEN_W     = SUM_W;
  localparam int Q_W       = COORD_W;
  localparam int DIV_STEPS = Q_W;

  // Viewport registers and products.
  localparam int SIZE_W = 14;
  localparam int VP_W   = COORD_W + SIZE_W + 1;

  // Visibility threshold of 0.001 in fixed point, rounded.
  localparam longint THRESH = ((longint'(1) << FRAC_BITS) + 500) / 1000;

  // Scale applied to clip x and y of points behind the near limit.
  localparam longint VIS_SCALE = 100000;
  localparam longint SCALE_LIM = 64'sd2147483647 / VIS_SCALE;

  localparam logic [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W-1){1'b1}}};
  localparam logic [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W-1){1'b0}}};

  // Register map, 8 bytes per register.
  localparam int ADDR_W = 6;
  localparam int DATA_W = 64;
  localparam int IDX_W  = 3;

  typedef enum logic [IDX_W-1:0] {
    REG_ROW0_AB = 3'd0,
    REG_ROW0_CD = 3'd1,
    REG_ROW1_AB = 3'd2,
    REG_ROW1_CD = 3'd3,
    REG_ROW3_AB = 3'd4,
    REG_ROW3_CD = 3'd5,
    REG_WIDTH   = 3'd6,
    REG_HEIGHT  = 3'd7
  } reg_idx_t;

  localparam logic [SIZE_W-1:0] WIDTH_RST  = 14'd1920;
  localparam logic [SIZE_W-1:0] HEIGHT_RST = 14'd1080;

endpackage

// ----- rtl/wsp_div_pipe.sv -----
// Pipelined restoring divider: quotient of (mag << FRAC_BITS) / den, one
// quotient bit per stage. Flags overflow when the quotient needs more than
// Q_W bits. All stages advance together when en is high.
module wsp_div_pipe
  import wsp_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] mag,
  input  logic [DEN_W-1:0] den,
  output logic [Q_W-1:0]   quot,
  output logic             ovf
);

  localparam int NUM_W = MAG_W + FRAC_BITS;
  localparam int TOP_W = NUM_W - Q_W;

  logic [DEN_W-1:0] p_r   [0:DIV_STEPS];
  logic [DEN_W-1:0] d_r   [0:DIV_STEPS];
  logic [Q_W-1:0]   lo_r  [0:DIV_STEPS];
  logic [Q_W-1:0]   q_r   [0:DIV_STEPS];
  logic             ovf_r [0:DIV_STEPS];

  logic [NUM_W-1:0] num;
  logic [DEN_W-1:0] p0;

  // Split the shifted dividend: the top part is the first partial remainder.
  assign num = {mag, {FRAC_BITS{1'b0}}};
  assign p0  = DEN_W'(num[NUM_W-1:Q_W]);

  // Entry stage: load operands and check for quotient overflow.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r[0]   <= p0;
      d_r[0]   <= den;
      lo_r[0]  <= num[Q_W-1:0];
      q_r[0]   <= '0;
      ovf_r[0] <= (DEN_W'(num[NUM_W-1:Q_W]) >= den) || (TOP_W > DEN_W);
    end
  end

  // One compare and subtract per stage.
  for (genvar k = 1; k <= DIV_STEPS; k++) begin : g_step
    logic [DEN_W:0] trial;
    logic           take;

    assign trial = {p_r[k-1], lo_r[k-1][Q_W-1]};
    assign take  = trial >= {1'b0, d_r[k-1]};

    always_ff @(posedge clk) begin
      if (en) begin
        p_r[k]   <= take ? DEN_W'(trial - {1'b0, d_r[k-1]}) : DEN_W'(trial);
        d_r[k]   <= d_r[k-1];
        lo_r[k]  <= {lo_r[k-1][Q_W-2:0], 1'b0};
        q_r[k]   <= {q_r[k-1][Q_W-2:0], take};
        ovf_r[k] <= ovf_r[k-1];
      end
    end
  end

  assign quot = q_r[DIV_STEPS];
  assign ovf  = ovf_r[DIV_STEPS];

endmodule

// ----- rtl/world_to_screen_projection.sv -----
// Throughput: one point per cycle; the pipeline moves whenever the output
// register is empty or being taken, and the divider's 33 stages set the depth.
// Reset (synchronous, rst_n low) clears all valid bits, coefficients to zero
// and the viewport to 1920 x 1080.
module world_to_screen_projection
  import wsp_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic signed [COORD_W-1:0] in_pos_x,
  input  logic signed [COORD_W-1:0] in_pos_y,
  input  logic signed [COORD_W-1:0] in_pos_z,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_visible,
  output logic signed [COORD_W-1:0] out_screen_x,
  output logic signed [COORD_W-1:0] out_screen_y,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [ADDR_W-1:0]         paddr,
  input  logic [DATA_W-1:0]         pwdata,
  output logic [DATA_W-1:0]         prdata,
  output logic                      pready
);

  typedef struct packed {
    logic               vis;
    logic               neg_x;
    logic               neg_y;
    logic [COORD_W-1:0] scx;
    logic [COORD_W-1:0] scy;
  } side_t;

  localparam int NPROD = 9;

  // Configuration registers.
  logic [DATA_W-1:0] coef_r [0:5];
  logic [SIZE_W-1:0] width_r;
  logic [SIZE_W-1:0] height_r;
  reg_idx_t          widx;
  logic              en;

  assign pready = 1'b1;
  assign widx   = reg_idx_t'(paddr[ADDR_W-1:ADDR_W-IDX_W]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 6; i++) coef_r[i] <= '0;
      width_r  <= WIDTH_RST;
      height_r <= HEIGHT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (widx)
        REG_WIDTH:  width_r  <= pwdata[SIZE_W-1:0];
        REG_HEIGHT: height_r <= pwdata[SIZE_W-1:0];
        default:    coef_r[widx] <= pwdata;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    unique case (widx)
      REG_WIDTH:  prdata = DATA_W'(width_r);
      REG_HEIGHT: prdata = DATA_W'(height_r);
      default:    prdata = coef_r[widx];
    endcase
  end

  // The whole pipeline stalls only while a finished result waits.
  logic out_valid_r;
  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  // Stage A: capture the input transaction.
  logic                      va_r;
  logic signed [COORD_W-1:0] x_r, y_r, z_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
    end else if (en) begin
      va_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r <= in_pos_x;
      y_r <= in_pos_y;
      z_r <= in_pos_z;
    end
  end

  // Stage B: nine products, each floored to the fixed-point grid.
  logic                       vb_r;
  logic signed [PROD_W-1:0]   prod_r [0:NPROD-1];
  logic signed [COORD_W-1:0]  mcoef  [0:NPROD-1];
  logic signed [COORD_W-1:0]  mpos   [0:NPROD-1];
  logic signed [2*COORD_W-1:0] mfull [0:NPROD-1];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      mcoef[3*r]   = coef_r[2*r][COORD_W-1:0];
      mcoef[3*r+1] = coef_r[2*r][2*COORD_W-1:COORD_W];
      mcoef[3*r+2] = coef_r[2*r+1][COORD_W-1:0];
      mpos[3*r]    = x_r;
      mpos[3*r+1]  = y_r;
      mpos[3*r+2]  = z_r;
    end
    for (int i = 0; i < NPROD; i++) begin
      mfull[i] = mcoef[i] * mpos[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vb_r <= 1'b0;
    end else if (en) begin
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NPROD; i++) prod_r[i] <= mfull[i][2*COORD_W-1:FRAC_BITS];
    end
  end

  // Stage C: dot products for clip x, clip y and clip w.
  logic                    vc_r;
  logic signed [SUM_W-1:0] clip_r [0:2];
  logic signed [SUM_W-1:0] clip_nxt [0:2];

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      clip_nxt[r] = SUM_W'(prod_r[3*r]) + SUM_W'(prod_r[3*r+1])
                  + SUM_W'(prod_r[3*r+2])
                  + SUM_W'($signed(coef_r[2*r+1][2*COORD_W-1:COORD_W]));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int r = 0; r < 3; r++) clip_r[r] <= clip_nxt[r];
    end
  end

  // Stage D: visibility test, scaled clip values and divider operands.
  function automatic logic [COORD_W-1:0] scale_clip(logic signed [SUM_W-1:0] c);
    logic signed [2*COORD_W-1:0] m;
    m = (2*COORD_W)'(c) * (2*COORD_W)'(VIS_SCALE);
    if (c > SUM_W'(SCALE_LIM)) begin
      return COORD_MAX;
    end else if (c < -SUM_W'(SCALE_LIM)) begin
      return COORD_MIN;
    end
    return m[COORD_W-1:0];
  endfunction

  logic             vd_r;
  side_t            side_d_r;
  logic [MAG_W-1:0] mag_x_r, mag_y_r;
  logic [DEN_W-1:0] den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vd_r <= 1'b0;
    end else if (en) begin
      vd_r <= vc_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_d_r.vis   <= clip_r[2] >= SUM_W'(THRESH);
      side_d_r.neg_x <= clip_r[0][SUM_W-1];
      side_d_r.neg_y <= clip_r[1][SUM_W-1];
      side_d_r.scx   <= scale_clip(clip_r[0]);
      side_d_r.scy   <= scale_clip(clip_r[1]);
      mag_x_r <= clip_r[0][SUM_W-1] ? MAG_W'(-clip_r[0]) : MAG_W'(clip_r[0]);
      mag_y_r <= clip_r[1][SUM_W-1] ? MAG_W'(-clip_r[1]) : MAG_W'(clip_r[1]);
      den_r   <= DEN_W'(clip_r[2]);
    end
  end

  // Divider lanes for x and y, with side data travelling alongside.
  logic [Q_W-1:0] qx, qy;
  logic           ovx, ovy;

  wsp_div_pipe u_div_x (
    .clk  (clk),
    .en   (en),
    .mag  (mag_x_r),
    .den  (den_r),
    .quot (qx),
    .ovf  (ovx)
  );

  wsp_div_pipe u_div_y (
    .clk  (clk),
    .en   (en),
    .mag  (mag_y_r),
    .den  (den_r),
    .quot (qy),
    .ovf  (ovy)
  );

  logic  vs_r   [0:DIV_STEPS];
  side_t side_r [0:DIV_STEPS];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= DIV_STEPS; k++) vs_r[k] <= 1'b0;
    end else if (en) begin
      vs_r[0] <= vd_r;
      for (int k = 1; k <= DIV_STEPS; k++) vs_r[k] <= vs_r[k-1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_d_r;
      for (int k = 1; k <= DIV_STEPS; k++) side_r[k] <= side_r[k-1];
    end
  end

  // Stage E: sign and saturation of the normalized coordinates.
  function automatic logic [COORD_W-1:0] ndc_clamp(logic [Q_W-1:0] q, logic ov,
                                                   logic neg);
    if (neg) begin
      if (ov || q > Q_W'(COORD_MIN)) return COORD_MIN;
      return COORD_W'(-q);
    end
    if (ov || q[Q_W-1]) return COORD_MAX;
    return COORD_W'(q);
  endfunction

  logic                      ve_r;
  side_t                     side_e_r;
  logic signed [COORD_W-1:0] nx_r, ny_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ve_r <= 1'b0;
    end else if (en) begin
      ve_r <= vs_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_e_r <= side_r[DIV_STEPS];
      nx_r     <= ndc_clamp(qx, ovx, side_r[DIV_STEPS].neg_x);
      ny_r     <= ndc_clamp(qy, ovy, side_r[DIV_STEPS].neg_y);
    end
  end

  // Stage F: scale by the viewport size.
  logic                   vf_r;
  side_t                  side_f_r;
  logic signed [VP_W-1:0] mx_r, my_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vf_r <= 1'b0;
    end else if (en) begin
      vf_r <= ve_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_f_r <= side_e_r;
      mx_r     <= VP_W'(nx_r) * $signed(VP_W'(width_r));
      my_r     <= VP_W'(ny_r) * $signed(VP_W'(height_r));
    end
  end

  // Stage G: center offset, floor half and saturation into the output register.
  function automatic logic [COORD_W-1:0] sat_half(logic signed [VP_W:0] s);
    logic signed [VP_W:0] h;
    h = s >>> 1;
    if (h > (VP_W+1)'($signed(COORD_MAX))) return COORD_MAX;
    if (h < (VP_W+1)'($signed(COORD_MIN))) return COORD_MIN;
    return h[COORD_W-1:0];
  endfunction

  logic signed [VP_W:0] sum_x, sum_y;
  logic                 vis_r;
  logic [COORD_W-1:0]   sx_r, sy_r;

  assign sum_x = $signed((VP_W+1)'({width_r, {FRAC_BITS{1'b0}}})) + (VP_W+1)'(mx_r);
  assign sum_y = $signed((VP_W+1)'({height_r, {FRAC_BITS{1'b0}}})) - (VP_W+1)'(my_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vf_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vis_r <= side_f_r.vis;
      sx_r  <= side_f_r.vis ? sat_half(sum_x) : side_f_r.scx;
      sy_r  <= side_f_r.vis ? sat_half(sum_y) : side_f_r.scy;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_visible  = vis_r;
  assign out_screen_x = sx_r;
  assign out_screen_y = sy_r;

  // A stalled pipeline keeps the last divider-lane valid bit and the stage E valid bit.
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(vs_r[DIV_STEPS]) && $stable(ve_r))
    else $error("pipeline valid moved during a stall");

  // The last stage always lands in the output register when the pipe moves.
  a_last_stage: assert property (@(posedge clk) disable iff (!rst_n)
    en && vf_r |=> out_valid_r)
    else $error("transaction lost before the output register");

  // A visible point always has a clip w at or above the threshold.
  a_vis_den: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r && side_d_r.vis |-> $signed(den_r) >= DEN_W'(THRESH))
    else $error("visible point with clip w below threshold");

endmodule
